FILE: hdl/hldf_pkg.sv
// ----------------------------------------------------------------------------
// hldf_pkg
// shared types and constants of the header/length frame deframer
// ----------------------------------------------------------------------------
package hldf_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 3;

    // register indexes, taken from paddr[2]
    localparam logic REG_FIRST_HEADER  = 1'b0;
    localparam logic REG_SECOND_HEADER = 1'b1;

    localparam logic [BYTE_W-1:0] FIRST_HEADER_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'h55;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_EOF     = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] position;
        logic [BYTE_W-1:0] frame_length;
        logic              is_last;
    } t_result;

endpackage

FILE: hdl/header_length_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// header_length_frame_deframer_core
// byte-stream parser for frames of header, type, length, payload, checksum
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  rx        in         i_in_valid / o_in_stall        i_rx_byte
//  result    out        o_out_valid / i_out_stall      o_kind .. o_is_last
//  config    in         apb (psel, penable, pwrite)    paddr, pwdata, prdata
//
//  one received byte is taken per cycle while o_in_stall is low; it is
//  parsed in the same cycle and any result is registered
//  a result register plus a skid stage decouple the two sides: o_in_stall
//  rises only when both hold a result; until then the rate is one byte per cycle
//  synchronous active-low reset puts the parser back to hunting the first
//  header byte and restores the header registers to 0xaa and 0x55
// ----------------------------------------------------------------------------
module header_length_frame_deframer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // received bytes
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [hldf_pkg::BYTE_W-1:0]       i_rx_byte,
    // parsed results
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_kind,
    output logic [hldf_pkg::BYTE_W-1:0]       o_frame_type,
    output logic [hldf_pkg::BYTE_W-1:0]       o_data_byte,
    output logic [hldf_pkg::BYTE_W-1:0]       o_position,
    output logic [hldf_pkg::BYTE_W-1:0]       o_frame_length,
    output logic                              o_is_last,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hldf_pkg::APB_AW-1:0]       paddr,
    input  logic [hldf_pkg::APB_DW-1:0]       pwdata,
    output logic [hldf_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    logic [hldf_pkg::BYTE_W-1:0] first_header;
    logic [hldf_pkg::BYTE_W-1:0] second_header;
    logic                        in_take;
    logic                        res_valid;
    logic                        skid_full;
    hldf_pkg::t_result           res;
    hldf_pkg::t_result           out_res;

    // header values, written through apb
    hldf_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_first_header  (first_header),
        .o_second_header (second_header)
    );

    // a byte is taken whenever the skid stage has room
    assign o_in_stall = skid_full;
    assign in_take    = i_in_valid && !skid_full;

    // frame state machine, advances once per accepted byte
    hldf_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (in_take),
        .i_rx_byte       (i_rx_byte),
        .i_first_header  (first_header),
        .i_second_header (second_header),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // payload and end-of-frame results wait here for the consumer
    hldf_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_take && res_valid),
        .i_res   (res),
        .o_full  (skid_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_frame_type   = out_res.frame_type;
    assign o_data_byte    = out_res.data_byte;
    assign o_position     = out_res.position;
    assign o_frame_length = out_res.frame_length;
    assign o_is_last      = out_res.is_last;

endmodule

FILE: hdl/hldf_apb_regs.sv
// ----------------------------------------------------------------------------
// hldf_apb_regs
// apb register file holding the two header byte values
// ----------------------------------------------------------------------------
module hldf_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hldf_pkg::APB_AW-1:0]       paddr,
    input  logic [hldf_pkg::APB_DW-1:0]       pwdata,
    output logic [hldf_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    output logic [hldf_pkg::BYTE_W-1:0]       o_first_header,
    output logic [hldf_pkg::BYTE_W-1:0]       o_second_header
);

    logic [hldf_pkg::BYTE_W-1:0] r_first_header;
    logic [hldf_pkg::BYTE_W-1:0] r_second_header;
    logic                        wr_en;
    logic                        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_header  <= hldf_pkg::FIRST_HEADER_RST;
            r_second_header <= hldf_pkg::SECOND_HEADER_RST;
        end else if (wr_en) begin
            if (reg_idx == hldf_pkg::REG_FIRST_HEADER) begin
                r_first_header <= pwdata[hldf_pkg::BYTE_W-1:0];
            end else begin
                r_second_header <= pwdata[hldf_pkg::BYTE_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == hldf_pkg::REG_FIRST_HEADER) begin
            prdata[hldf_pkg::BYTE_W-1:0] = r_first_header;
        end else begin
            prdata[hldf_pkg::BYTE_W-1:0] = r_second_header;
        end
    end

    assign o_first_header  = r_first_header;
    assign o_second_header = r_second_header;

endmodule

FILE: hdl/hldf_parser.sv
// ----------------------------------------------------------------------------
// hldf_parser
// frame state machine: header hunt, type, length, payload and checksum
// ----------------------------------------------------------------------------
module hldf_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [hldf_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic [hldf_pkg::BYTE_W-1:0] i_first_header,
    input  logic [hldf_pkg::BYTE_W-1:0] i_second_header,
    output logic                        o_res_valid,
    output hldf_pkg::t_result           o_res
);

    localparam logic [2:0] PH_HUNT_FIRST  = 3'd0;
    localparam logic [2:0] PH_HUNT_SECOND = 3'd1;
    localparam logic [2:0] PH_TYPE        = 3'd2;
    localparam logic [2:0] PH_LENGTH      = 3'd3;
    localparam logic [2:0] PH_PAYLOAD     = 3'd4;
    localparam logic [2:0] PH_CHECKSUM    = 3'd5;

    logic [2:0]                  r_phase,  n_phase;
    logic [hldf_pkg::BYTE_W-1:0] r_type,   n_type;
    logic [hldf_pkg::BYTE_W-1:0] r_length, n_length;
    logic [hldf_pkg::BYTE_W-1:0] r_count,  n_count;
    logic [hldf_pkg::BYTE_W:0]   pos_next;

    assign pos_next = {1'b0, r_count} + {{hldf_pkg::BYTE_W{1'b0}}, 1'b1};

    always_comb begin
        n_phase          = r_phase;
        n_type           = r_type;
        n_length         = r_length;
        n_count          = r_count;
        o_res_valid      = 1'b0;
        o_res.kind       = hldf_pkg::KIND_PAYLOAD;
        o_res.frame_type = r_type;
        o_res.data_byte  = i_rx_byte;
        o_res.position   = r_count;
        o_res.frame_length = r_length;
        o_res.is_last    = 1'b0;
        case (r_phase)
            PH_HUNT_SECOND: begin
                if (i_rx_byte == i_second_header) begin
                    n_phase = PH_TYPE;
                end else if (i_rx_byte == i_first_header) begin
                    n_phase = PH_HUNT_SECOND;
                end else begin
                    n_phase = PH_HUNT_FIRST;
                end
            end
            PH_TYPE: begin
                n_type  = i_rx_byte;
                n_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_length = i_rx_byte;
                n_count  = '0;
                n_phase  = (i_rx_byte == '0) ? PH_CHECKSUM : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                o_res_valid = 1'b1;
                n_count     = pos_next[hldf_pkg::BYTE_W-1:0];
                if (pos_next >= {1'b0, r_length}) begin
                    n_phase = PH_CHECKSUM;
                end
            end
            PH_CHECKSUM: begin
                o_res_valid     = 1'b1;
                o_res.kind      = hldf_pkg::KIND_EOF;
                o_res.data_byte = '0;
                o_res.position  = '0;
                o_res.is_last   = 1'b1;
                n_phase         = PH_HUNT_FIRST;
            end
            default: begin
                // hunting, and any code with no meaning
                n_phase = (i_rx_byte == i_first_header) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT_FIRST;
            r_type   <= '0;
            r_length <= '0;
            r_count  <= '0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_length <= n_length;
            r_count  <= n_count;
        end
    end

endmodule

FILE: hdl/hldf_out_skid.sv
// ----------------------------------------------------------------------------
// hldf_out_skid
// result register with a skid stage so the input side keeps flowing
// ----------------------------------------------------------------------------
module hldf_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hldf_pkg::t_result i_res,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output hldf_pkg::t_result o_res
);

    logic              r_out_valid;
    logic              r_skid_valid;
    hldf_pkg::t_result r_out;
    hldf_pkg::t_result r_skid;
    logic              out_pop;

    assign out_pop = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !out_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !out_pop) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result in the output register");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("request pushed while skid stage full");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_out_valid && i_stall) |=> r_skid_valid)
        else $error("result lost while output stalled");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved to output register");
`endif

endmodule
